FILE: rtl/halfstep_stepper_sequencer_defines.svh
// assertion macros for the half-step stepper sequencer
`ifndef HALFSTEP_STEPPER_SEQUENCER_DEFINES_SVH
`define HALFSTEP_STEPPER_SEQUENCER_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define HSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define HSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/hss_pkg.sv
package hss_pkg;

  // defaults for the top-level parameters
  localparam int unsigned TIMER_BITS_DEF    = 24;
  localparam int unsigned POSITION_BITS_DEF = 16;

  // field widths
  localparam int unsigned REV_W   = 16;
  localparam int unsigned DELAY_W = 24;
  localparam int unsigned STEPS_W = 16;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned COIL_W  = 4;
  localparam int unsigned OP_W    = 2;

  // configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [REV_W-1:0]   STEPS_PER_REV_RST = REV_W'(200);
  localparam logic [DELAY_W-1:0] STEP_DELAY_RST    = '0;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_STEPS_PER_REV = 1'b0,
    REG_STEP_DELAY    = 1'b1
  } reg_idx_e;

  // item operation codes; code 3 is a no-op
  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_MOVE    = 2'd1,
    OP_DISABLE = 2'd2
  } op_e;

  // half-step phases A, AB, B, BC, C, CD, D, DA in pin order (A, C, B, D)
  function automatic logic [COIL_W-1:0] phase_pins(input logic [2:0] phase);
    logic [COIL_W-1:0] pins;
    case (phase)
      3'd0:    pins = 4'h1;
      3'd1:    pins = 4'h5;
      3'd2:    pins = 4'h4;
      3'd3:    pins = 4'h6;
      3'd4:    pins = 4'h2;
      3'd5:    pins = 4'hA;
      3'd6:    pins = 4'h8;
      3'd7:    pins = 4'h9;
      default: pins = 4'h0;
    endcase
    return pins;
  endfunction

endpackage

FILE: rtl/hss_if.sv
// command item channel
interface hss_in_if;
  logic                                valid;
  logic                                ready;
  logic [hss_pkg::OP_W-1:0]            op;
  logic signed [hss_pkg::STEPS_W-1:0]  move_steps;

  modport source (output valid, output op, output move_steps, input ready);
  modport sink   (input valid, input op, input move_steps, output ready);
endinterface

// result item channel
interface hss_out_if;
  logic                          valid;
  logic                          ready;
  logic [hss_pkg::COIL_W-1:0]    coil_drive;
  logic                          step_taken;
  logic                          busy_res;
  logic [hss_pkg::STEPS_W-1:0]   steps_remaining;
  logic [hss_pkg::POS_W-1:0]     position;

  modport source (output valid, output coil_drive, output step_taken, output busy_res,
                  output steps_remaining, output position, input ready);
  modport sink   (input valid, input coil_drive, input step_taken, input busy_res,
                  input steps_remaining, input position, output ready);
endinterface

FILE: rtl/halfstep_stepper_sequencer.sv
// half-step sequencer for a four-coil unipolar stepper. every command item
// (tick, move, disable; code 3 is a no-op) gives exactly one result item
// showing the state after it. throughput is one item per clock cycle:
// the next state and the result are worked out in one pass from the
// state registers and land in a single result register, which takes a
// new item in the same cycle its old item is taken, so only a stalled
// result slot holds off the input. a tick advances a saturating
// microsecond counter and, when steps remain and the counter has reached
// step_delay_us, moves one step (forward wraps to 0 at steps_per_rev,
// backward from 0 goes to steps_per_rev-1) and drives the half-step
// pattern for position mod 8. registers on the apb port: steps_per_rev at
// 0x0, step_delay_us at 0x4; write them only while no result is pending.
// no clearing pass after reset: the block takes items right away.
`include "halfstep_stepper_sequencer_defines.svh"

module halfstep_stepper_sequencer #(
  parameter int unsigned TIMER_BITS    = hss_pkg::TIMER_BITS_DEF,
  parameter int unsigned POSITION_BITS = hss_pkg::POSITION_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  hss_in_if.sink                      req_i,
  hss_out_if.source                   rsp_o,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [hss_pkg::APB_AW-1:0]  paddr_i,
  input  logic [hss_pkg::APB_DW-1:0]  pwdata_i,
  output logic [hss_pkg::APB_DW-1:0]  prdata_o,
  output logic                        pready_o
);

  // compare widths wide enough for both sides
  localparam int unsigned CW = (POSITION_BITS + 1 > hss_pkg::REV_W) ?
                               POSITION_BITS + 1 : hss_pkg::REV_W;
  localparam int unsigned DW = (TIMER_BITS > hss_pkg::DELAY_W) ?
                               TIMER_BITS : hss_pkg::DELAY_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  // result item register
  typedef struct packed {
    logic [hss_pkg::COIL_W-1:0]  coil_drive;
    logic                        step_taken;
    logic                        busy_res;
    logic [hss_pkg::STEPS_W-1:0] steps_remaining;
    logic [hss_pkg::POS_W-1:0]   position;
  } rsp_t;

  // configuration registers
  logic [hss_pkg::REV_W-1:0]   steps_per_rev_q;
  logic [hss_pkg::DELAY_W-1:0] step_delay_q;

  // motor state
  logic [POSITION_BITS-1:0]    position_q, position_d;
  logic [hss_pkg::STEPS_W-1:0] remaining_q, remaining_d;
  logic                        forward_q, forward_d;
  logic [TIMER_BITS-1:0]       elapsed_q, elapsed_d;
  logic [hss_pkg::COIL_W-1:0]  coil_q, coil_d;

  logic rsp_valid_q, rsp_valid_d;
  rsp_t rsp_q, rsp_d;

  logic accept;
  logic cfg_write;

  // tick path
  logic [TIMER_BITS-1:0]       elapsed_inc;
  logic                        delay_reached;
  logic [CW-1:0]               pos_plus;
  logic [CW-1:0]               rev_minus;
  logic [POSITION_BITS-1:0]    pos_fwd, pos_bwd, pos_step;
  logic                        stepped;
  logic [CW-1:0]               pos_out;
  logic [hss_pkg::STEPS_W-1:0] move_mag;
  logic                        move_neg;

  // ---------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------
  assign pready_o  = 1'b1;
  assign cfg_write = psel_i & penable_i & pwrite_i & pready_o;

  always_comb begin
    case (hss_pkg::reg_idx_e'(paddr_i[2]))
      hss_pkg::REG_STEPS_PER_REV: prdata_o = hss_pkg::APB_DW'(steps_per_rev_q);
      hss_pkg::REG_STEP_DELAY:    prdata_o = hss_pkg::APB_DW'(step_delay_q);
      default:                    prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_per_rev_q <= hss_pkg::STEPS_PER_REV_RST;
      step_delay_q    <= hss_pkg::STEP_DELAY_RST;
    end else if (cfg_write) begin
      case (hss_pkg::reg_idx_e'(paddr_i[2]))
        hss_pkg::REG_STEPS_PER_REV: steps_per_rev_q <= pwdata_i[hss_pkg::REV_W-1:0];
        hss_pkg::REG_STEP_DELAY:    step_delay_q    <= pwdata_i[hss_pkg::DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // handshake: result slot frees when taken, new item may enter same cycle
  // ---------------------------------------------------------------------
  assign req_i.ready = ~rsp_valid_q | rsp_o.ready;
  assign accept      = req_i.valid & req_i.ready;

  // ---------------------------------------------------------------------
  // step arithmetic
  // ---------------------------------------------------------------------
  // saturating microsecond counter
  assign elapsed_inc   = (elapsed_q != TIMER_MAX) ? elapsed_q + 1'b1 : elapsed_q;
  assign delay_reached = DW'(elapsed_inc) >= DW'(step_delay_q);

  // forward wraps when position+1 hits the revolution size
  assign pos_plus  = CW'(position_q) + 1'b1;
  assign pos_fwd   = (pos_plus == CW'(steps_per_rev_q)) ? '0 : pos_plus[POSITION_BITS-1:0];
  // backward from zero goes to revolution size minus one
  assign rev_minus = CW'(steps_per_rev_q) - 1'b1;
  assign pos_bwd   = (position_q == '0) ? rev_minus[POSITION_BITS-1:0]
                                        : position_q - 1'b1;
  assign pos_step  = forward_q ? pos_fwd : pos_bwd;

  // move count: magnitude of a negative count, zero counts as backward
  assign move_neg = req_i.move_steps[hss_pkg::STEPS_W-1];
  assign move_mag = move_neg ? (~req_i.move_steps + 1'b1) : req_i.move_steps;

  always_comb begin
    position_d  = position_q;
    remaining_d = remaining_q;
    forward_d   = forward_q;
    elapsed_d   = elapsed_q;
    coil_d      = coil_q;
    stepped     = 1'b0;
    case (req_i.op)
      hss_pkg::OP_TICK: begin
        elapsed_d = elapsed_inc;
        if ((remaining_q != '0) && delay_reached) begin
          elapsed_d   = '0;
          position_d  = pos_step;
          coil_d      = hss_pkg::phase_pins(pos_step[2:0]);
          remaining_d = remaining_q - 1'b1;
          stepped     = 1'b1;
        end
      end
      hss_pkg::OP_MOVE: begin
        // replaces any move in progress; coils and timer untouched
        forward_d   = ~move_neg & (req_i.move_steps != '0);
        remaining_d = move_mag;
      end
      hss_pkg::OP_DISABLE: begin
        coil_d      = '0;
        remaining_d = '0;
      end
      default: ;
    endcase
  end

  // result shows the state after the item
  assign pos_out = CW'(position_d);

  always_comb begin
    rsp_d.coil_drive      = coil_d;
    rsp_d.step_taken      = stepped;
    rsp_d.busy_res        = remaining_d != '0;
    rsp_d.steps_remaining = remaining_d;
    rsp_d.position        = pos_out[hss_pkg::POS_W-1:0];
  end

  assign rsp_valid_d = accept ? 1'b1 : (rsp_o.ready ? 1'b0 : rsp_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q  <= '0;
      remaining_q <= '0;
      forward_q   <= 1'b0;
      elapsed_q   <= '0;
      coil_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
      if (accept) begin
        position_q  <= position_d;
        remaining_q <= remaining_d;
        forward_q   <= forward_d;
        elapsed_q   <= elapsed_d;
        coil_q      <= coil_d;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.coil_drive      = rsp_q.coil_drive;
  assign rsp_o.step_taken      = rsp_q.step_taken;
  assign rsp_o.busy_res        = rsp_q.busy_res;
  assign rsp_o.steps_remaining = rsp_q.steps_remaining;
  assign rsp_o.position        = rsp_q.position;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // a stalled result must hold off the input
  `HSS_ASSERT_NOW(a_no_overrun, rsp_valid_q && !rsp_o.ready, !req_i.ready, "result overrun")
  // disable leaves coils off and no move pending
  `HSS_ASSERT_NEXT(a_disable_off, accept && req_i.op == hss_pkg::OP_DISABLE,
                   rsp_o.valid && rsp_o.coil_drive == '0 && !rsp_o.busy_res,
                   "disable did not stop the motor")
  // a move command never steps by itself
  `HSS_ASSERT_NEXT(a_move_no_step, accept && req_i.op == hss_pkg::OP_MOVE,
                   rsp_o.valid && !rsp_o.step_taken, "move item stepped")
  // a step energizes coils and restarts the timer
  `HSS_ASSERT_NOW(a_step_coils, rsp_valid_q && rsp_q.step_taken,
                  rsp_q.coil_drive != '0 && (elapsed_q == '0 || !$stable(elapsed_q)),
                  "step without coil drive or timer restart")

endmodule
